### hdl/rfid_tag_barcode_decode_core_defines.svh
// Assertion macros used by the barcode decoder's checker file, rtbd_checker.sv.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef RFID_TAG_BARCODE_DECODE_CORE_DEFINES_SVH
`define RFID_TAG_BARCODE_DECODE_CORE_DEFINES_SVH

// A condition that must hold at every clock edge.
`define RTBD_ASSERT_HOLDS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("rtbd: invariant violated");

// A consequence that must hold in the same cycle as its cause.
`define RTBD_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rtbd: same-cycle implication violated");

// A consequence that must hold in the cycle after its cause.
`define RTBD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rtbd: next-cycle implication violated");

`endif

### hdl/rtbd_pkg.sv
// Shared types and constants of the RFID tag barcode decoder.
// Used by the front, queue, back and checker modules; depends on nothing.
package rtbd_pkg;

	localparam int NUM_DIGITS    = 10;
	localparam int BCD_BITS      = NUM_DIGITS * 4;
	localparam int BIN_BITS      = 30;
	localparam int BITS_PER_STEP = 3;
	localparam int CONV_STEPS    = BIN_BITS / BITS_PER_STEP;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	// Lengths below this are copied bytes; from here up they are packed fields.
	localparam logic [3:0] SHORT_LIMIT = 4'd8;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_BAD_LEN  = 2'd1,
		STATUS_TOO_WIDE = 2'd2
	} status_t;

	typedef logic [NUM_DIGITS-1:0][3:0] bcd_t;

	typedef struct packed {
		logic [31:0] word_low;
		logic [31:0] word_high;
		bcd_t        digits;
		status_t     status;
	} entry_t;

endpackage

### hdl/rfid_tag_barcode_decode_core.sv
// RFID tag barcode decoder, top level.
// Input queue side: present tag_word_low / tag_word_high with push; the item is
// taken on a clock edge where push is high and full is low.
// Result queue side: while empty is low, one character of the barcode sits on
// char_code / char_pos / last_char / status; pop takes it. last_char marks the
// final character of a tag. A bad length or a number too wide for its field
// gives a single result with char_code 0, char_pos 0 and last_char set.
// Path: a short code or a bad length passes from the front's input registers
// through the queue to the output register; a long code first goes through the
// decimal conversion (three bits per cycle through the digit shifter).
// Flow: the output stage gives one character per cycle while pop is high, and a
// tag has up to 14 characters. The front takes a short code or a bad length
// every cycle while the queue has room, and no new item during a long code's
// conversion; a two-entry queue sits between so each side stalls on its own.
// While pop stays low only the output register stalls; the queue fills, then full rises.
// Reset empties the queue and output register; no state is kept between tags.
module rfid_tag_barcode_decode_core #(
	parameter int MAX_CHARS = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic [31:0] tag_word_low,
	input  logic [31:0] tag_word_high,
	output logic        full,
	input  logic        pop,
	output logic        empty,
	output logic [7:0]  char_code,
	output logic [3:0]  char_pos,
	output logic        last_char,
	output logic [1:0]  status
);
	import rtbd_pkg::*;

	entry_t q_wr_data;
	entry_t q_rd_data;
	logic   q_push;
	logic   q_full;
	logic   q_pop;
	logic   q_empty;

	rtbd_front #(
		.MAX_CHARS(MAX_CHARS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.tag_word_low (tag_word_low),
		.tag_word_high(tag_word_high),
		.full         (full),
		.q_push       (q_push),
		.q_data       (q_wr_data),
		.q_full       (q_full)
	);

	rtbd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wr_data(q_wr_data),
		.full   (q_full),
		.rd_en  (q_pop),
		.rd_data(q_rd_data),
		.empty  (q_empty)
	);

	rtbd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_rd_data),
		.head_valid(!q_empty),
		.head_pop  (q_pop),
		.empty     (empty),
		.pop       (pop),
		.char_code (char_code),
		.char_pos  (char_pos),
		.last_char (last_char),
		.status    (status)
	);

endmodule

### hdl/rtbd_fifo.sv
// Short queue of classified tags between the front and back of the decoder.
// Depends on rtbd_pkg for the entry type and depth.
module rtbd_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  rtbd_pkg::entry_t wr_data,
	output logic            full,
	input  logic            rd_en,
	output rtbd_pkg::entry_t rd_data,
	output logic            empty
);
	import rtbd_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	entry_t             slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     count_q;

	assign full    = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slots_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

### hdl/rtbd_front.sv
// Front of the barcode decoder: takes a tag, classifies its length and converts
// the packed number to decimal digits. Depends on rtbd_pkg; feeds rtbd_fifo.
module rtbd_front #(
	parameter int MAX_CHARS = 14
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [31:0]      tag_word_low,
	input  logic [31:0]      tag_word_high,
	output logic             full,
	output logic             q_push,
	output rtbd_pkg::entry_t q_data,
	input  logic             q_full
);
	import rtbd_pkg::*;

	localparam int STEP_W = $clog2(CONV_STEPS);

	typedef enum logic [2:0] {
		FS_IDLE = 3'b001,
		FS_CONV = 3'b010,
		FS_PUSH = 3'b100
	} front_state_t;

	// One double-dabble step: correct each digit, then shift one binary bit in.
	function automatic bcd_t dabble_step(input bcd_t d, input logic b);
		bcd_t                adj;
		logic [BCD_BITS-1:0] flat;
		adj = d;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (d[i] >= 4'd5) begin
				adj[i] = d[i] + 4'd3;
			end
		end
		flat = adj;
		return bcd_t'({flat[BCD_BITS-2:0], b});
	endfunction

	// Number of significant digits; zero still counts as one digit.
	function automatic logic [3:0] digit_count(input bcd_t d);
		logic [3:0] n;
		n = 4'd1;
		for (int i = 1; i < NUM_DIGITS; i++) begin
			if (d[i] != 4'd0) begin
				n = 4'(i + 1);
			end
		end
		return n;
	endfunction

	front_state_t          state_q;
	front_state_t          next_after_take;
	logic [STEP_W-1:0]     step_q;
	logic [31:0]           low_q;
	logic [31:0]           high_q;
	logic                  bad_q;
	logic                  long_q;
	logic [BIN_BITS-1:0]   bin_q;
	bcd_t                  bcd_q;
	bcd_t                  conv;
	logic [3:0]            len_in;
	logic                  in_bad;
	logic                  in_long;
	logic                  take;
	logic [3:0]            num_digits;
	logic                  too_wide;

	assign len_in  = tag_word_low[3:0];
	assign in_bad  = (len_in == 4'd0) || (len_in > 4'(MAX_CHARS));
	assign in_long = !in_bad && (len_in >= SHORT_LIMIT);
	assign next_after_take = in_long ? FS_CONV : FS_PUSH;

	// A new item may enter in the same cycle that the finished one leaves.
	assign q_push = (state_q == FS_PUSH) && !q_full;
	assign full   = !((state_q == FS_IDLE) || q_push);
	assign take   = push && !full;

	always_comb begin
		conv = bcd_q;
		for (int j = 0; j < BITS_PER_STEP; j++) begin
			conv = dabble_step(conv, bin_q[BIN_BITS-1-j]);
		end
	end

	// The digits fill positions 4 up to len-2, which leaves len-5 places.
	assign num_digits = digit_count(bcd_q);
	assign too_wide   = long_q && ((num_digits + 4'd5) > low_q[3:0]);

	always_comb begin
		q_data.word_low  = low_q;
		q_data.word_high = high_q;
		q_data.digits    = bcd_q;
		if (bad_q) begin
			q_data.status = STATUS_BAD_LEN;
		end else if (too_wide) begin
			q_data.status = STATUS_TOO_WIDE;
		end else begin
			q_data.status = STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				FS_IDLE: begin
					if (take) begin
						state_q <= next_after_take;
						step_q  <= '0;
					end
				end
				FS_CONV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(CONV_STEPS-1)) begin
						state_q <= FS_PUSH;
					end
				end
				FS_PUSH: begin
					if (take) begin
						state_q <= next_after_take;
						step_q  <= '0;
					end else if (q_push) begin
						state_q <= FS_IDLE;
					end
				end
				default: begin
					state_q <= FS_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			low_q  <= tag_word_low;
			high_q <= tag_word_high;
			bad_q  <= in_bad;
			long_q <= in_long;
			bin_q  <= tag_word_high[31:2];
			bcd_q  <= '0;
		end else if (state_q == FS_CONV) begin
			bcd_q <= conv;
			bin_q <= {bin_q[BIN_BITS-BITS_PER_STEP-1:0], {BITS_PER_STEP{1'b0}}};
		end
	end

endmodule

### hdl/rtbd_back.sv
// Back of the barcode decoder: walks the queued tag one character per cycle,
// as pop allows, into an output register. Depends on rtbd_pkg; reads rtbd_fifo.
module rtbd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  rtbd_pkg::entry_t head,
	input  logic             head_valid,
	output logic             head_pop,
	output logic             empty,
	input  logic             pop,
	output logic [7:0]       char_code,
	output logic [3:0]       char_pos,
	output logic             last_char,
	output logic [1:0]       status
);
	import rtbd_pkg::*;

	logic [3:0]  pos_q;
	logic        out_valid_q;
	logic [7:0]  char_q;
	logic [3:0]  cpos_q;
	logic        last_q;
	status_t     status_q;

	logic [3:0]  len;
	logic        is_err;
	logic [63:0] tag_bits;
	logic [63:0] shifted;
	logic [3:0]  digit_idx;
	logic [3:0]  digit;
	logic [7:0]  cur_char;
	logic        cur_last;
	logic        advance;
	logic        emit;

	assign len     = head.word_low[3:0];
	assign is_err  = (head.status != STATUS_OK);
	assign advance = !out_valid_q || pop;
	assign emit    = advance && head_valid;
	assign head_pop = emit && cur_last;

	always_comb begin
		tag_bits  = {head.word_high, head.word_low};
		shifted   = tag_bits >> {pos_q + 4'd1, 3'b000};
		// Digits are right-aligned, so the one just left of the raw byte is the units.
		digit_idx = len - 4'd2 - pos_q;
		digit     = (digit_idx < 4'(NUM_DIGITS)) ? head.digits[digit_idx] : 4'd0;
		cur_last  = is_err || (pos_q == len - 4'd1);
		if (is_err) begin
			cur_char = 8'd0;
		end else if (len < SHORT_LIMIT) begin
			cur_char = shifted[7:0];
		end else begin
			case (pos_q)
				4'd0: cur_char = {2'b00, head.word_low[29:24]} + ASCII_ZERO;
				4'd1: cur_char = {2'b00, head.word_low[23:18]} + ASCII_ZERO;
				4'd2: cur_char = {2'b00, head.word_low[17:12]} + ASCII_ZERO;
				4'd3: cur_char = {4'b0000, head.word_high[1:0], head.word_low[31:30]}
					+ ASCII_ZERO;
				default: begin
					if (pos_q == len - 4'd1) begin
						cur_char = head.word_low[11:4];
					end else begin
						cur_char = {4'b0000, digit} + ASCII_ZERO;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= head_valid;
			end
			if (emit) begin
				pos_q <= cur_last ? 4'd0 : pos_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_q   <= cur_char;
			cpos_q   <= is_err ? 4'd0 : pos_q;
			last_q   <= cur_last;
			status_q <= head.status;
		end
	end

	assign empty     = !out_valid_q;
	assign char_code = char_q;
	assign char_pos  = cpos_q;
	assign last_char = last_q;
	assign status    = status_q;

endmodule

### hdl/rtbd_checker.sv
// Port-level checks of the barcode decoder's result stream, bound to the top level.
// Depends on rtbd_pkg and rfid_tag_barcode_decode_core_defines.svh.
`include "rfid_tag_barcode_decode_core_defines.svh"

module rtbd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       pop,
	input logic       empty,
	input logic [7:0] char_code,
	input logic [3:0] char_pos,
	input logic       last_char,
	input logic [1:0] status
);
	import rtbd_pkg::*;

	// An error is always reported as one lone, blank result.
	`RTBD_ASSERT_IMPLIES(a_err_single, !empty && status != STATUS_OK, last_char && char_pos == 4'd0 && char_code == 8'd0)

	`RTBD_ASSERT_HOLDS(a_status_code, empty || status == STATUS_OK || status == STATUS_BAD_LEN || status == STATUS_TOO_WIDE)

	// Within a tag the characters follow each other with no gap.
	`RTBD_ASSERT_NEXT(a_pos_step, !empty && pop && !last_char, !empty && char_pos == $past(char_pos) + 4'd1)

	// The next tag starts over at position zero.
	`RTBD_ASSERT_NEXT(a_pos_restart, !empty && pop && last_char, empty || char_pos == 4'd0)

	`RTBD_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(char_code) && $stable(char_pos) && $stable(last_char) && $stable(status))

endmodule

bind rfid_tag_barcode_decode_core rtbd_checker u_rtbd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.pop      (pop),
	.empty    (empty),
	.char_code(char_code),
	.char_pos (char_pos),
	.last_char(last_char),
	.status   (status)
);

### dv/tb_rfid_tag_barcode_decode_core.sv
// Testbench for rfid_tag_barcode_decode_core: drives tags through the push side,
// predicts each barcode character and checks every popped result in order.
// Depends on rtbd_pkg and the decoder RTL.
`timescale 1ns / 100ps

module tb_rfid_tag_barcode_decode_core;
	import rtbd_pkg::*;

	localparam int MAX_CHARS   = 14;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct {
		logic [7:0] code;
		logic [3:0] pos;
		logic       is_last;
		status_t    st;
	} barcode_char_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic [31:0] tag_word_low = '0;
	logic [31:0] tag_word_high = '0;
	logic        full;
	logic        pop = 1'b0;
	logic        empty;
	logic [7:0]  char_code;
	logic [3:0]  char_pos;
	logic        last_char;
	logic [1:0]  status;

	barcode_char_t expected_chars[$];
	int            mismatch_count = 0;
	int            cycle_count = 0;
	int            pop_stall = 0;
	bit            no_idle = 1'b0;

	rfid_tag_barcode_decode_core #(
		.MAX_CHARS(MAX_CHARS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.tag_word_low(tag_word_low),
		.tag_word_high(tag_word_high),
		.full(full),
		.pop(pop),
		.empty(empty),
		.char_code(char_code),
		.char_pos(char_pos),
		.last_char(last_char),
		.status(status)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		$display("ERROR @%0t: %s", $realtime, what);
		mismatch_count++;
	endtask

	// Mostly short gaps, now and then a long one; none at all while no_idle is set.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99, 0);
		if (no_idle || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(10, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic longint pow10(input int n);
		longint p;
		p = 1;
		repeat (n) p = p * 10;
		return p;
	endfunction

	function automatic void add_error(input status_t st);
		barcode_char_t c;
		c.code = 8'h00;
		c.pos = 4'd0;
		c.is_last = 1'b1;
		c.st = st;
		expected_chars.push_back(c);
	endfunction

	// Expected characters of one tag, appended in emission order.
	function automatic void predict_barcode(input logic [31:0] lo, input logic [31:0] hi);
		logic [7:0]  text [16];
		logic [3:0]  dig [10];
		logic [63:0] tag;
		logic [29:0] num;
		logic [3:0]  len;
		int          nd;
		int          room;
		barcode_char_t c;
		tag = {hi, lo};
		len = lo[3:0];
		if (len == 4'd0 || len > MAX_CHARS) begin
			add_error(STATUS_BAD_LEN);
			return;
		end
		if (len < SHORT_LIMIT) begin
			for (int k = 0; k < len; k++)
				text[k] = tag[8*(k+1) +: 8];
		end else begin
			for (int k = 0; k < 16; k++)
				text[k] = ASCII_ZERO;
			text[len - 1] = lo[11:4];
			text[0] = {2'b00, lo[29:24]} + ASCII_ZERO;
			text[1] = {2'b00, lo[23:18]} + ASCII_ZERO;
			text[2] = {2'b00, lo[17:12]} + ASCII_ZERO;
			text[3] = {4'b0000, hi[1:0], lo[31:30]} + ASCII_ZERO;
			num = hi[31:2];
			nd = 0;
			// Zero still prints as one digit.
			do begin
				dig[nd] = 4'(num % 10);
				num = 30'(num / 10);
				nd++;
			end while (num != 0 && nd < 10);
			room = len - 5;
			if (nd > room) begin
				add_error(STATUS_TOO_WIDE);
				return;
			end
			for (int k = 0; k < nd; k++)
				text[len - 2 - k] = {4'b0000, dig[k]} + ASCII_ZERO;
		end
		for (int k = 0; k < len; k++) begin
			c.code = text[k];
			c.pos = k[3:0];
			c.is_last = (k == len - 1);
			c.st = STATUS_OK;
			expected_chars.push_back(c);
		end
	endfunction

	// Holds the item on the ports until it is taken, then records its characters.
	task automatic send_tag(input logic [63:0] tag);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		tag_word_low <= tag[31:0];
		tag_word_high <= tag[63:32];
		do @(posedge clk); while (full);
		predict_barcode(tag[31:0], tag[63:32]);
	endtask

	// A long code tag: fill supplies the packed character fields and the raw byte.
	function automatic logic [63:0] long_tag(input logic [3:0] len, input logic [29:0] num,
			input logic [31:0] fill);
		return {num, fill[1:0], fill[31:4], len};
	endfunction

	function automatic logic [29:0] fitting_number(input int room);
		int d;
		d = $urandom_range(room, 1);
		if (d == 1)
			return 30'($urandom_range(9, 0));
		return 30'($urandom_range(32'(pow10(d) - 1), 32'(pow10(d - 1))));
	endfunction

	always @(posedge clk) begin : result_check
		barcode_char_t exp_c;
		if (arst_n && pop && !empty) begin
			if (expected_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected result code %02h pos %0d last %0b status %0d",
					char_code, char_pos, last_char, status));
			end else begin
				exp_c = expected_chars.pop_front();
				if (char_code !== exp_c.code)
					report_mismatch($sformatf("char_code %02h, expected %02h at pos %0d",
						char_code, exp_c.code, exp_c.pos));
				if (char_pos !== exp_c.pos)
					report_mismatch($sformatf("char_pos %0d, expected %0d",
						char_pos, exp_c.pos));
				if (last_char !== exp_c.is_last)
					report_mismatch($sformatf("last_char %0b, expected %0b at pos %0d",
						last_char, exp_c.is_last, exp_c.pos));
				if (status !== exp_c.st)
					report_mismatch($sformatf("status %0d, expected %0d at pos %0d",
						status, exp_c.st, exp_c.pos));
			end
		end
		if (pop_stall > 0) begin
			pop <= 1'b0;
			pop_stall <= pop_stall - 1;
		end else begin
			pop <= 1'b1;
			pop_stall <= pick_gap();
		end
	end

	task automatic test_short_codes();
		send_tag({32'h0000_0000, 24'h00_0000, 8'h01});
		for (int len = 2; len < 7; len++)
			send_tag({$urandom(), 28'($urandom_range(32'h0FFF_FFFF, 0)), 4'(len)});
		send_tag({32'hFFFF_FFFF, 28'hFFF_FFFF, 4'd7});
		send_tag({32'h0000_0000, 28'h000_0000, 4'd7});
	endtask

	task automatic test_bad_lengths();
		send_tag(64'h0000_0000_0000_0000);
		send_tag(64'hFFFF_FFFF_FFFF_FFFF);
	endtask

	task automatic test_long_codes();
		// The widest number that fits each length, content alternating zeros and ones.
		for (int len = 8; len <= MAX_CHARS; len++)
			send_tag(long_tag(4'(len), 30'(pow10(len - 5) - 1), (len % 2) ? '1 : '0));
		send_tag(long_tag(4'd8, 30'd1000, $urandom()));
		send_tag(long_tag(4'd14, 30'h3FFF_FFFF, '1));
		send_tag(long_tag(4'd14, 30'd0, '0));
		send_tag(long_tag(4'd9, 30'd0, '1));
	endtask

	task automatic test_random_tags();
		int r;
		int len;
		for (int i = 0; i < 130; i++) begin
			// Every other stretch of forty items runs with no idling on either side.
			no_idle = ((i / 40) % 2) == 1;
			r = $urandom_range(99, 0);
			if (r < 8) begin
				send_tag({$urandom(), $urandom()});
			end else if (r < 16) begin
				send_tag({$urandom(), 28'($urandom_range(32'h0FFF_FFFF, 0)),
					($urandom_range(1, 0) == 1) ? 4'd15 : 4'd0});
			end else if (r < 40) begin
				send_tag({$urandom(), 28'($urandom_range(32'h0FFF_FFFF, 0)),
					4'($urandom_range(7, 1))});
			end else begin
				len = $urandom_range(MAX_CHARS, 8);
				if (r < 85)
					send_tag(long_tag(4'(len), fitting_number(len - 5), $urandom()));
				else
					send_tag(long_tag(4'(len), 30'($urandom()), $urandom()));
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_short_codes();
		test_bad_lengths();
		test_long_codes();
		test_random_tags();
		push <= 1'b0;
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
